FILE: rtl/gtl_pkg.sv
// ----------------------------------------------------------------------------
// gtl_pkg
// Types and constants shared by the glyph text layout block.
// ----------------------------------------------------------------------------
package gtl_pkg;

    // Command codes of an input item
    typedef enum logic [1:0] {
        CMD_DEFINE = 2'd0,
        CMD_RENDER = 2'd1,
        CMD_CLEAR  = 2'd2
    } t_cmd;

    // Configuration register indexes
    localparam logic REG_SPACE_WIDTH = 1'b0;
    localparam logic REG_DRAW_LAYER  = 1'b1;

    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 8;

    localparam logic [7:0] SPACE_WIDTH_RESET = 8'd8;
    localparam logic [6:0] SPACE_CODE        = 7'd32;

    typedef struct packed {
        logic [1:0]  cmd;
        logic [6:0]  char_code;
        logic [9:0]  glyph_src_x;
        logic [9:0]  glyph_src_y;
        logic [7:0]  glyph_width;
        logic [7:0]  glyph_height;
        logic        first;
        logic signed [15:0] start_x;
        logic signed [15:0] start_y;
        logic [2:0]  scale_shift;
    } t_in;

    typedef struct packed {
        logic [3:0]  layer;
        logic signed [15:0] dest_x;
        logic signed [15:0] dest_y;
        logic [14:0] dest_w;
        logic [14:0] dest_h;
        logic [9:0]  src_x;
        logic [9:0]  src_y;
        logic [2:0]  scale;
    } t_out;

    // One glyph table entry as stored in memory
    typedef struct packed {
        logic [9:0] sx;
        logic [9:0] sy;
        logic [7:0] w;
        logic [7:0] h;
    } t_glyph;

endpackage

FILE: rtl/gtl_ram.sv
// ----------------------------------------------------------------------------
// gtl_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module gtl_ram #(
    parameter int WIDTH = 36,
    parameter int DEPTH = 128
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: rtl/glyph_text_layout.sv
// ----------------------------------------------------------------------------
// glyph_text_layout
// Bitmap-font text layout: glyph table plus pen cursor, emits sprite draws.
// ----------------------------------------------------------------------------
// Takes one item per clock, sustained, unless a stalled output register holds
// the input side, which it does only when the waiting item wants to emit. An
// item is accepted into a lookup stage: define items write the glyph table
// memory right there, clear items drop every per-entry valid flag at once, and
// render items read the table entry for their character. Once the item is in
// the layout stage its read data is back, and that stage applies the pen: a
// glyph with nonzero width becomes a draw command in the output register, a
// space without a glyph only moves the pen. A draw command passes from the
// lookup-to-layout register into the output register. The pen add sits in the
// layout stage, so it does not limit the rate. Configuration (space width,
// draw layer) is written through the plain write port.
// ----------------------------------------------------------------------------
module glyph_text_layout #(
    parameter int GLYPH_COUNT = 128
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // input item channel
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  gtl_pkg::t_in                      i_in,
    // draw command channel
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output gtl_pkg::t_out                     o_out,
    // configuration write port
    input  logic                              i_cfg_we,
    input  logic [gtl_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [gtl_pkg::CFG_DATA_W-1:0]    i_cfg_data
);
    import gtl_pkg::*;

    localparam int AW = $clog2(GLYPH_COUNT);

    // configuration
    logic [7:0] r_space_width;
    logic [3:0] r_draw_layer;

    // per-entry flag: entry may hold a nonzero width
    logic [GLYPH_COUNT-1:0] r_gvalid;

    // lookup-to-layout stage
    logic   r_s1_valid;
    t_in    r_s1;
    logic   r_s1_hit;
    t_glyph s1_glyph;
    logic [$bits(t_glyph)-1:0] ram_rdata;

    // pen state
    logic [15:0] r_pen;
    logic [15:0] r_line;
    logic [2:0]  r_scale;

    // output register
    logic r_out_valid;
    t_out r_out;

    // handshake and control
    logic        in_acc;
    logic        out_free;
    logic        s1_adv;
    logic        s1_render;
    logic        s1_emit;
    logic        s1_space;
    logic [7:0]  code_ext;
    logic        in_table;
    logic [AW-1:0] addr;
    logic        tbl_we;
    t_glyph      wr_glyph;
    logic [15:0] pen_base;
    logic [15:0] line_base;
    logic [2:0]  scale_base;
    logic [14:0] sw;
    logic [14:0] sh;
    logic [14:0] space_adv;
    logic [15:0] pen_next;

    // ---------------- lookup stage ----------------
    assign code_ext = {1'b0, i_in.char_code};
    assign in_table = {1'b0, code_ext} < 9'(GLYPH_COUNT);
    assign addr     = code_ext[AW-1:0];

    assign out_free   = !r_out_valid || !i_out_stall;
    assign o_in_stall = r_s1_valid && !s1_adv;
    assign in_acc     = i_in_valid && !o_in_stall;

    assign tbl_we   = in_acc && (i_in.cmd == CMD_DEFINE) && in_table;
    assign wr_glyph = '{sx: i_in.glyph_src_x, sy: i_in.glyph_src_y,
                        w: i_in.glyph_width, h: i_in.glyph_height};

    // writes land at accept, so a following render always sees them
    gtl_ram #(
        .WIDTH ($bits(t_glyph)),
        .DEPTH (GLYPH_COUNT)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (tbl_we),
        .i_waddr (addr),
        .i_wdata (wr_glyph),
        .i_re    (in_acc),
        .i_raddr (addr),
        .o_rdata (ram_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gvalid <= '0;
        end else if (in_acc && (i_in.cmd == CMD_CLEAR)) begin
            r_gvalid <= '0;
        end else if (tbl_we) begin
            r_gvalid[addr] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (in_acc) begin
            r_s1_valid <= 1'b1;
        end else if (s1_adv) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_s1     <= i_in;
            r_s1_hit <= in_table && r_gvalid[addr];
        end
    end

    // ---------------- layout stage ----------------
    assign s1_glyph  = t_glyph'(ram_rdata);
    assign s1_render = (r_s1.cmd == CMD_RENDER);
    assign s1_emit   = s1_render && r_s1_hit && (s1_glyph.w != 8'd0);
    assign s1_space  = s1_render && !s1_emit && (r_s1.char_code == SPACE_CODE);

    // a non-emitting item never waits on the output register
    assign s1_adv = r_s1_valid && (!s1_emit || out_free);

    assign pen_base   = r_s1.first ? r_s1.start_x     : r_pen;
    assign line_base  = r_s1.first ? r_s1.start_y     : r_line;
    assign scale_base = r_s1.first ? r_s1.scale_shift : r_scale;

    assign sw        = 15'({7'd0, s1_glyph.w} << scale_base);
    assign sh        = 15'({7'd0, s1_glyph.h} << scale_base);
    assign space_adv = 15'({7'd0, r_space_width} << scale_base);

    always_comb begin
        pen_next = pen_base;
        if (s1_emit) begin
            pen_next = pen_base + {1'b0, sw};
        end else if (s1_space) begin
            pen_next = pen_base + {1'b0, space_adv};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pen   <= '0;
            r_line  <= '0;
            r_scale <= '0;
        end else if (s1_adv && s1_render) begin
            r_pen   <= pen_next;
            r_line  <= line_base;
            r_scale <= scale_base;
        end
    end

    // ---------------- output register ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_adv && s1_emit) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_adv && s1_emit) begin
            r_out.layer  <= r_draw_layer;
            r_out.dest_x <= pen_base;
            r_out.dest_y <= line_base;
            r_out.dest_w <= sw;
            r_out.dest_h <= sh;
            r_out.src_x  <= s1_glyph.sx;
            r_out.src_y  <= s1_glyph.sy;
            r_out.scale  <= scale_base;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    // ---------------- configuration ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_space_width <= SPACE_WIDTH_RESET;
            r_draw_layer  <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_SPACE_WIDTH: r_space_width <= i_cfg_data;
                REG_DRAW_LAYER:  r_draw_layer  <= i_cfg_data[3:0];
                default: ;
            endcase
        end
    end

    // ---------------- assertions ----------------
    a_stall_needs_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_s1_valid |-> !o_in_stall)
        else $error("input stalled with empty layout stage");

    a_clear_drops_all: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && i_in.cmd == CMD_CLEAR) |=> (r_gvalid == '0))
        else $error("clear left a glyph flagged valid");

    a_emit_has_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s1_adv && s1_emit) |-> out_free)
        else $error("draw command overwrote a waiting item");

    a_pen_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s1_adv && !s1_render && !in_acc) |=> $stable(r_pen))
        else $error("pen moved on a non-render item");

endmodule
